// File: rtl/core/hse_pkg.sv
// shared types, constants and length helper for the hamming stream encoder
`timescale 1ns / 1ps

package hse_pkg;

    localparam int LEN_W         = 11;   // data_length register width
    localparam int MAX_DATA_BITS = 1024;
    localparam int CHK_MAX       = 11;   // check bits needed at the largest length
    localparam int CHK_W         = 4;
    localparam int POS_W         = 11;   // holds the largest codeword position
    localparam int NUM_RES       = 3;
    localparam int CNT_W         = 2;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int TDATA_W       = 8;

    localparam logic [LEN_W-1:0]   DATA_LENGTH_RST = LEN_W'(8);
    localparam logic [PADDR_W-3:0] REG_DATA_LENGTH = '0;

    typedef struct packed {
        logic code_bit;
        logic is_check_bit;
        logic last_of_codeword;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0]        count;
        t_item [NUM_RES-1:0]     items;   // items[0] goes out first
    } t_step_res;

    typedef struct packed {
        logic             load;       // config write, restart at load_pos
        logic [POS_W-1:0] load_pos;
        logic [POS_W-1:0] start_pos;  // top position of the current length
    } t_restart_ctl;

    // m + r for a raw register value, r smallest with 2^r >= m + r + 1
    function automatic logic [POS_W-1:0] calc_start(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0]   m;
        logic [CHK_W-1:0]   r;
        logic               found;
        logic [POS_W+1:0]   lim;
        m = len;
        if (m == '0) begin
            m = LEN_W'(1);
        end else if (m > LEN_W'(MAX_DATA_BITS)) begin
            m = LEN_W'(MAX_DATA_BITS);
        end
        r     = '0;
        found = 1'b0;
        for (int k = 0; k <= CHK_MAX; k++) begin
            lim = (POS_W+2)'(1) << k;
            if (!found && lim >= (POS_W+2)'(m) + (POS_W+2)'(k) + (POS_W+2)'(1)) begin
                r     = CHK_W'(k);
                found = 1'b1;
            end
        end
        return POS_W'(m) + POS_W'(r);
    endfunction

    localparam logic [POS_W-1:0] START_POS_RST = calc_start(DATA_LENGTH_RST);

endpackage

// File: rtl/core/hse_step.sv
// position counter, parity accumulator and per-bit result generation
`timescale 1ns / 1ps

module hse_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hse_pkg::t_restart_ctl i_ctl,
    input  logic                 i_accept,
    input  logic                 i_data_bit,
    output hse_pkg::t_step_res   o_res
);
    import hse_pkg::*;

    logic [POS_W-1:0] r_position, n_position;
    logic [POS_W-1:0] r_acc, n_acc;

    logic [POS_W-1:0] acc1, p1, p2, p3;
    logic             pow1, pow2;

    always_comb begin
        acc1 = i_data_bit ? (r_acc ^ r_position) : r_acc;
        p1   = r_position - POS_W'(1);
        p2   = p1 - POS_W'(1);
        p3   = p2 - POS_W'(1);
        pow1 = (p1 != '0) && ((p1 & p2) == '0);
        pow2 = pow1 && (p2 != '0) && ((p2 & p3) == '0);

        o_res = '0;
        o_res.items[0].code_bit = i_data_bit;
        // check bit at 2^k is accumulator bit k: select it with the one-hot position
        o_res.items[1].code_bit         = |(acc1 & p1);
        o_res.items[1].is_check_bit     = 1'b1;
        o_res.items[1].last_of_codeword = (p1 == POS_W'(1));
        o_res.items[2].code_bit         = |(acc1 & p2);
        o_res.items[2].is_check_bit     = 1'b1;
        o_res.items[2].last_of_codeword = (p2 == POS_W'(1));
        if (pow2) begin
            o_res.count = CNT_W'(3);
            n_position  = p3;
        end else if (pow1) begin
            o_res.count = CNT_W'(2);
            n_position  = p2;
        end else begin
            o_res.count = CNT_W'(1);
            n_position  = p1;
        end
        n_acc = acc1;
        if (n_position == '0) begin
            n_position = i_ctl.start_pos;
            n_acc      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= START_POS_RST;
            r_acc      <= '0;
        end else if (i_ctl.load) begin
            r_position <= i_ctl.load_pos;
            r_acc      <= '0;
        end else if (i_accept) begin
            r_position <= n_position;
            r_acc      <= n_acc;
        end
    end

endmodule

// File: rtl/core/hse_out_buf.sv
// three-entry result buffer that drains one transfer per cycle while the output is ready
`timescale 1ns / 1ps

module hse_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  hse_pkg::t_step_res i_res,
    input  logic               i_m_tready,
    output logic               o_m_tvalid,
    output hse_pkg::t_item     o_item,
    output logic               o_room
);
    import hse_pkg::*;

    logic [CNT_W-1:0]     r_count, n_count;
    t_item [NUM_RES-1:0]  r_items, n_items;
    logic                 pop;

    assign o_m_tvalid = (r_count != '0);
    assign o_item     = r_items[0];
    assign pop        = o_m_tvalid && i_m_tready;
    // new results may enter once the last pending one leaves
    assign o_room     = (r_count == '0) || (r_count == CNT_W'(1) && i_m_tready);

    always_comb begin
        n_count = r_count;
        n_items = r_items;
        if (i_load) begin
            n_count = i_res.count;
            n_items = i_res.items;
        end else if (pop) begin
            n_count    = r_count - CNT_W'(1);
            n_items[0] = r_items[1];
            n_items[1] = r_items[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_items <= n_items;
    end

endmodule

// File: rtl/core/hamming_stream_encoder_core.sv
// streaming hamming encoder: config register, bit step logic and result buffer
// the first result of a data bit is registered and offered the cycle after its input transfer
// input rate: one data bit per cycle while each bit yields one result and the output is ready;
//   a bit followed by check bits holds off the next data bit until the result buffer has
//   drained its results, one output transfer at a time
// reset: data_length 8, codeword of 12 bits starts at position 12, buffer empty
`timescale 1ns / 1ps

module hamming_stream_encoder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [hse_pkg::TDATA_W-1:0]   i_s_tdata,   // [0] data_bit, rest zero
    // master stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [hse_pkg::TDATA_W-1:0]   o_m_tdata,   // [0] code_bit, rest zero
    output logic [0:0]                    o_m_tuser,   // [0] is_check_bit
    output logic                          o_m_tlast,   // last_of_codeword
    // config port
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [hse_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [hse_pkg::PDATA_W-1:0]   i_pwdata,
    output logic [hse_pkg::PDATA_W-1:0]   o_prdata,
    output logic                          o_pready
);
    import hse_pkg::*;

    logic [LEN_W-1:0] r_data_length;
    logic [POS_W-1:0] r_start_pos;
    logic             cfg_wr;
    logic [LEN_W-1:0] wr_len;
    logic [POS_W-1:0] wr_start;
    logic             s_accept;
    t_restart_ctl     ctl;
    t_step_res        res;
    t_item            item;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite
                   && (i_paddr[PADDR_W-1:2] == REG_DATA_LENGTH);
    assign wr_len   = i_pwdata[LEN_W-1:0];
    assign wr_start = calc_start(wr_len);
    assign o_prdata = (i_paddr[PADDR_W-1:2] == REG_DATA_LENGTH)
                    ? {{(PDATA_W-LEN_W){1'b0}}, r_data_length} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_length <= DATA_LENGTH_RST;
            r_start_pos   <= START_POS_RST;
        end else if (cfg_wr) begin
            r_data_length <= wr_len;
            r_start_pos   <= wr_start;
        end
    end

    assign ctl.load      = cfg_wr;
    assign ctl.load_pos  = wr_start;
    assign ctl.start_pos = r_start_pos;
    assign s_accept      = i_s_tvalid && o_s_tready;

    hse_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_accept   (s_accept),
        .i_data_bit (i_s_tdata[0]),
        .o_res      (res)
    );

    hse_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s_accept),
        .i_res      (res),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_item     (item),
        .o_room     (o_s_tready)
    );

    assign o_m_tdata = {{(TDATA_W-1){1'b0}}, item.code_bit};
    assign o_m_tuser = item.is_check_bit;
    assign o_m_tlast = item.last_of_codeword;

    // every accepted data bit shows up as a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> o_m_tvalid)
        else $error("no result after input transfer");

    // the final position of a codeword is always a check bit
    a_last_is_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> o_m_tuser[0])
        else $error("last bit not flagged as check bit");

    // an empty buffer never holds off the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty buffer");

    // a data bit is only accepted with a result pending when that result leaves in the same cycle
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && o_m_tvalid) |-> i_m_tready)
        else $error("input taken while results pending");

endmodule
